// ===== src/cvr_pkg.sv =====
// Shared constants and types for the clock-synced CV recorder.
// Depends on nothing; imported by cvr_div, clock_synced_cv_recorder_top and its testbench.
package cvr_pkg;

    localparam int TOTAL_BEATS_DEF    = 32;
    localparam int SUBSTEPS_DEF       = 4;

    localparam int TS_W               = 32;
    localparam int CV_W               = 12;
    localparam int SEL_W              = 4;
    localparam int KNOB_W             = 12;
    localparam int BEAT_W             = 5;
    localparam int SUB_W              = 4;
    localparam int MODE_W             = 2;
    localparam int LEN_W              = 6;

    localparam int LEN_COUNT          = 10;
    localparam logic [SEL_W-1:0] SEL_MAX = 4'd9;
    localparam logic [LEN_W-1:0] LEN_TAB [LEN_COUNT] = '{
        6'd1, 6'd2, 6'd3, 6'd4, 6'd6, 6'd8, 6'd12, 6'd16, 6'd24, 6'd32
    };

    // shared reciprocal multiplier: q = (x * recip) >> RCP_SHIFT
    localparam int DIV_W              = 32;
    localparam int RCP_W              = 40;
    localparam int RCP_CHUNK          = 10;
    localparam int RCP_SHIFT          = 36;

    // segment rounding: (nseg * knob * 2 + 4095) / 8190
    localparam logic [63:0]      SEG_DIVISOR = 64'd8190;
    localparam logic [RCP_W-1:0] SEG_RECIP   =
        RCP_W'(((64'd1 << RCP_SHIFT) + SEG_DIVISOR - 64'd1) / SEG_DIVISOR);
    localparam logic [DIV_W-1:0] ROUND_BIAS  = 32'd4095;

    typedef enum logic [MODE_W-1:0] {
        MODE_WAIT = 2'd0,
        MODE_REC  = 2'd1,
        MODE_PLAY = 2'd2
    } run_mode_t;

endpackage

// ===== src/cvr_div.sv =====
// Shared reciprocal multiplier: quotient = (dividend * recip) >> RCP_SHIFT,
// one RCP_CHUNK-bit slice of the reciprocal per cycle. Uses cvr_pkg.
module cvr_div (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       start,
    input  logic [cvr_pkg::DIV_W-1:0]  dividend,
    input  logic [cvr_pkg::RCP_W-1:0]  recip,
    output logic                       done,
    output logic [cvr_pkg::DIV_W-1:0]  quotient
);
    import cvr_pkg::*;

    localparam int STEPS  = RCP_W / RCP_CHUNK;
    localparam int CNT_W  = $clog2(STEPS);
    localparam int ACC_W  = DIV_W + RCP_W;
    localparam int PART_W = DIV_W + RCP_CHUNK;

    logic              busy_reg;
    logic              done_reg;
    logic [CNT_W-1:0]  cnt_reg;
    logic [DIV_W-1:0]  dvd_reg;
    logic [RCP_W-1:0]  rcp_reg;
    logic [ACC_W-1:0]  acc_reg;
    logic [PART_W-1:0] partial;
    logic [ACC_W-1:0]  acc_next;

    // top slice of the reciprocal first, accumulator shifted up each cycle
    assign partial  = PART_W'(dvd_reg) * PART_W'(rcp_reg[RCP_W-1 -: RCP_CHUNK]);
    assign acc_next = {acc_reg[ACC_W-RCP_CHUNK-1:0], {RCP_CHUNK{1'b0}}} + ACC_W'(partial);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else if (start)
        begin
            busy_reg <= 1'b1;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else if (busy_reg)
        begin
            cnt_reg <= cnt_reg + 1'b1;
            if (cnt_reg == CNT_W'(STEPS - 1))
            begin
                busy_reg <= 1'b0;
                done_reg <= 1'b1;
            end
        end
        else
        begin
            done_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            dvd_reg <= dividend;
            rcp_reg <= recip;
            acc_reg <= '0;
        end
        else if (busy_reg)
        begin
            acc_reg <= acc_next;
            rcp_reg <= {rcp_reg[RCP_W-RCP_CHUNK-1:0], {RCP_CHUNK{1'b0}}};
        end
    end

    assign done     = done_reg;
    assign quotient = acc_reg[RCP_SHIFT +: DIV_W];

    a_no_restart: assert property (@(posedge clk) disable iff (!rst_n)
        start |-> !busy_reg)
        else $error("divider restarted while busy");

    a_done_on_finish: assert property (@(posedge clk) disable iff (!rst_n)
        $fell(busy_reg) |-> done_reg)
        else $error("divider finished without done");

    a_done_pulse: assert property (@(posedge clk) disable iff (!rst_n)
        done_reg |=> !done_reg)
        else $error("done held longer than one cycle");

endmodule

// ===== src/clock_synced_cv_recorder_top.sv =====
// Clock-synced two-channel CV and gate recorder, top level.
// Uses cvr_pkg and cvr_div; holds the slot store as a local memory.
//
//   channel | handshake          | payload
//   --------+--------------------+--------------------------------------------
//   in      | in_valid, in_stall | time_now, clock_trigger, gate_level,
//           |                    | cv_a_sample, cv_b_sample, length_select,
//           |                    | segment_knob, record_switch, quantize_switch
//   out     | out_valid,out_stall| out_cv_a, out_cv_b, out_gate, beat_index,
//           |                    | substep_index, run_mode
//
// One poll at a time: each poll runs PREP, SEGDIV, ROW and WRITE, then READ and OUT
// when it has a result; a clock edge that advances the beat adds LENDIV, a second
// pass through the shared multiplier.
// After reset the store is cleared, one entry a cycle, all TOTAL_BEATS *
// SUBSTEPS_PER_BEAT entries, with in_stall high.
// A result waits in the output register; the next poll is taken meanwhile and
// holds in the output state while that register is still stalled.
module clock_synced_cv_recorder_top #(
    parameter int TOTAL_BEATS       = cvr_pkg::TOTAL_BEATS_DEF,
    parameter int SUBSTEPS_PER_BEAT = cvr_pkg::SUBSTEPS_DEF
) (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        in_valid,
    output logic                        in_stall,
    input  logic [cvr_pkg::TS_W-1:0]    time_now,
    input  logic                        clock_trigger,
    input  logic                        gate_level,
    input  logic [cvr_pkg::CV_W-1:0]    cv_a_sample,
    input  logic [cvr_pkg::CV_W-1:0]    cv_b_sample,
    input  logic [cvr_pkg::SEL_W-1:0]   length_select,
    input  logic [cvr_pkg::KNOB_W-1:0]  segment_knob,
    input  logic                        record_switch,
    input  logic                        quantize_switch,
    output logic                        out_valid,
    input  logic                        out_stall,
    output logic [cvr_pkg::CV_W-1:0]    out_cv_a,
    output logic [cvr_pkg::CV_W-1:0]    out_cv_b,
    output logic                        out_gate,
    output logic [cvr_pkg::BEAT_W-1:0]  beat_index,
    output logic [cvr_pkg::SUB_W-1:0]   substep_index,
    output logic [cvr_pkg::MODE_W-1:0]  run_mode
);
    import cvr_pkg::*;

    localparam int DEPTH  = TOTAL_BEATS * SUBSTEPS_PER_BEAT;
    localparam int ADDR_W = $clog2(DEPTH);
    localparam int SEG_W  = $clog2(TOTAL_BEATS);
    localparam int ROW_W  = SEG_W + 1;
    localparam int PROD_W = SEG_W + KNOB_W;
    localparam int MEM_W  = 2 * CV_W + 1;

    localparam logic [SUB_W-1:0]  SUB_LAST  = SUB_W'(SUBSTEPS_PER_BEAT - 1);
    localparam logic [ADDR_W-1:0] SUB_MUL   = ADDR_W'(SUBSTEPS_PER_BEAT);
    localparam logic [ADDR_W-1:0] ADDR_LAST = ADDR_W'(DEPTH - 1);
    localparam logic [63:0]       SUB_DIVISOR = 64'(SUBSTEPS_PER_BEAT);
    localparam logic [RCP_W-1:0]  SUB_RECIP   =
        RCP_W'(((64'd1 << RCP_SHIFT) + SUB_DIVISOR - 64'd1) / SUB_DIVISOR);

    // segments minus one for each loop length
    localparam logic [SEG_W-1:0] NSEG_TAB [LEN_COUNT] = '{
        SEG_W'(TOTAL_BEATS / int'(LEN_TAB[0]) - 1),
        SEG_W'(TOTAL_BEATS / int'(LEN_TAB[1]) - 1),
        SEG_W'(TOTAL_BEATS / int'(LEN_TAB[2]) - 1),
        SEG_W'(TOTAL_BEATS / int'(LEN_TAB[3]) - 1),
        SEG_W'(TOTAL_BEATS / int'(LEN_TAB[4]) - 1),
        SEG_W'(TOTAL_BEATS / int'(LEN_TAB[5]) - 1),
        SEG_W'(TOTAL_BEATS / int'(LEN_TAB[6]) - 1),
        SEG_W'(TOTAL_BEATS / int'(LEN_TAB[7]) - 1),
        SEG_W'(TOTAL_BEATS / int'(LEN_TAB[8]) - 1),
        SEG_W'(TOTAL_BEATS / int'(LEN_TAB[9]) - 1)
    };

    typedef enum logic [8:0] {
        S_CLEAR  = 9'b000000001,
        S_IDLE   = 9'b000000010,
        S_PREP   = 9'b000000100,
        S_SEGDIV = 9'b000001000,
        S_LENDIV = 9'b000010000,
        S_ROW    = 9'b000100000,
        S_WRITE  = 9'b001000000,
        S_READ   = 9'b010000000,
        S_OUT    = 9'b100000000
    } state_t;

    state_t              state_reg;
    logic [ADDR_W-1:0]   clr_addr_reg;

    // captured poll
    logic [TS_W-1:0]     now_reg;
    logic                trig_reg;
    logic                gate_reg;
    logic [CV_W-1:0]     cva_reg;
    logic [CV_W-1:0]     cvb_reg;
    logic [SEL_W-1:0]    sel_reg;
    logic [KNOB_W-1:0]   knob_reg;
    logic                rec_reg;
    logic                quant_reg;

    // recorder state
    run_mode_t           mode_reg;
    logic [TS_W-1:0]     cur_time_reg;
    logic [BEAT_W-1:0]   beat_reg;
    logic [SUB_W-1:0]    sub_reg;
    logic [TS_W-1:0]     sub_start_reg;
    logic [TS_W-1:0]     sub_len_reg;
    logic                changed_reg;
    logic                quant_lat_reg;
    logic [LEN_W-1:0]    loop_len_reg;
    logic [SEG_W-1:0]    seg_reg;
    logic                seen_reg;
    logic [SEG_W-1:0]    row_reg;

    logic [MEM_W-1:0]    store [DEPTH];
    logic [MEM_W-1:0]    rd_data_reg;

    logic                out_valid_reg;
    logic [CV_W-1:0]     out_cv_a_reg;
    logic [CV_W-1:0]     out_cv_b_reg;
    logic                out_gate_reg;
    logic [BEAT_W-1:0]   beat_out_reg;
    logic [SUB_W-1:0]    sub_out_reg;
    run_mode_t           mode_out_reg;

    logic [SEL_W-1:0]    sel_clamped;
    logic [LEN_W-1:0]    new_len;
    logic [PROD_W-1:0]   seg_prod;
    logic [DIV_W-1:0]    seg_num;
    run_mode_t           trig_mode;
    logic                advance;
    logic [LEN_W-1:0]    beat_inc;
    logic [BEAT_W-1:0]   beat_next;
    logic [TS_W-1:0]     elapsed;
    logic                sub_adv;
    logic [ROW_W-1:0]    row_calc;
    logic [ADDR_W-1:0]   slot_base;
    logic [ADDR_W-1:0]   wr_addr;
    logic [ADDR_W-1:0]   rd_addr;
    logic                mem_we;
    logic [ADDR_W-1:0]   mem_waddr;
    logic [MEM_W-1:0]    mem_wdata;
    logic                mem_re;
    logic                out_load;

    logic                div_start;
    logic [DIV_W-1:0]    div_dividend;
    logic [RCP_W-1:0]    div_recip;
    logic                div_done;
    logic [DIV_W-1:0]    div_quot;

    assign in_stall = (state_reg != S_IDLE);

    assign sel_clamped = (sel_reg inside {[4'd10:4'd15]}) ? SEL_MAX : sel_reg;
    assign new_len     = LEN_TAB[sel_clamped];
    assign seg_prod    = PROD_W'(NSEG_TAB[sel_clamped]) * PROD_W'(knob_reg);
    assign seg_num     = DIV_W'({seg_prod, 1'b0}) + ROUND_BIAS;

    // an edge seen while waiting, after an earlier edge, leaves waiting and already advances
    assign trig_mode = (mode_reg == MODE_WAIT && seen_reg) ? MODE_PLAY : mode_reg;
    assign advance   = trig_reg && (trig_mode != MODE_WAIT);
    assign beat_inc  = LEN_W'(beat_reg) + 1'b1;
    assign beat_next = (beat_inc == loop_len_reg) ? '0 : beat_inc[BEAT_W-1:0];
    assign elapsed   = now_reg - sub_start_reg;
    assign sub_adv   = (elapsed > sub_len_reg) && (sub_reg < SUB_LAST);

    assign row_calc  = ROW_W'(seg_reg) * ROW_W'(loop_len_reg) + ROW_W'(beat_reg);
    assign slot_base = ADDR_W'(row_reg) * SUB_MUL;
    assign wr_addr   = slot_base + ADDR_W'(sub_reg);
    assign rd_addr   = quant_lat_reg ? slot_base : wr_addr;

    assign mem_we    = (state_reg == S_CLEAR) ||
                       (state_reg == S_WRITE && mode_reg == MODE_REC && changed_reg);
    assign mem_waddr = (state_reg == S_CLEAR) ? clr_addr_reg : wr_addr;
    assign mem_wdata = (state_reg == S_CLEAR) ? '0 : {gate_reg, cvb_reg, cva_reg};
    assign mem_re    = (state_reg == S_READ);
    assign out_load  = (state_reg == S_OUT) && (!out_valid_reg || !out_stall);

    always_comb
    begin
        div_start    = 1'b0;
        div_dividend = seg_num;
        div_recip    = SEG_RECIP;
        if (state_reg == S_PREP)
        begin
            div_start = 1'b1;
        end
        else if (state_reg == S_SEGDIV && div_done && advance)
        begin
            div_start    = 1'b1;
            div_dividend = now_reg - cur_time_reg;
            div_recip    = SUB_RECIP;
        end
    end

    cvr_div u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_start),
        .dividend (div_dividend),
        .recip    (div_recip),
        .done     (div_done),
        .quotient (div_quot)
    );

    always_ff @(posedge clk)
    begin
        if (state_reg == S_IDLE && in_valid)
        begin
            now_reg   <= time_now;
            trig_reg  <= clock_trigger;
            gate_reg  <= gate_level;
            cva_reg   <= cv_a_sample;
            cvb_reg   <= cv_b_sample;
            sel_reg   <= length_select;
            knob_reg  <= segment_knob;
            rec_reg   <= record_switch;
            quant_reg <= quantize_switch;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_CLEAR;
            clr_addr_reg  <= '0;
            mode_reg      <= MODE_WAIT;
            cur_time_reg  <= '0;
            beat_reg      <= '0;
            sub_reg       <= '0;
            sub_start_reg <= '0;
            sub_len_reg   <= '0;
            changed_reg   <= 1'b0;
            quant_lat_reg <= 1'b0;
            loop_len_reg  <= LEN_TAB[0];
            seg_reg       <= '0;
            seen_reg      <= 1'b0;
            row_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (out_load)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_valid_reg && !out_stall)
            begin
                out_valid_reg <= 1'b0;
            end
            case (state_reg)
                S_CLEAR:
                begin
                    clr_addr_reg <= clr_addr_reg + 1'b1;
                    if (clr_addr_reg == ADDR_LAST)
                    begin
                        state_reg <= S_IDLE;
                    end
                end
                S_IDLE:
                begin
                    if (in_valid)
                    begin
                        state_reg <= S_PREP;
                    end
                end
                S_PREP:
                begin
                    if (new_len != loop_len_reg)
                    begin
                        loop_len_reg <= new_len;
                        beat_reg     <= '0;
                    end
                    state_reg <= S_SEGDIV;
                end
                S_SEGDIV:
                begin
                    if (div_done)
                    begin
                        seg_reg   <= div_quot[SEG_W-1:0];
                        state_reg <= advance ? S_LENDIV : S_ROW;
                        if (trig_reg)
                        begin
                            cur_time_reg <= now_reg;
                            if (mode_reg == MODE_WAIT)
                            begin
                                mode_reg <= trig_mode;
                                seen_reg <= 1'b1;
                            end
                            if (advance)
                            begin
                                beat_reg      <= beat_next;
                                sub_reg       <= '0;
                                sub_start_reg <= now_reg;
                                changed_reg   <= 1'b1;
                            end
                        end
                        else if (mode_reg != MODE_WAIT)
                        begin
                            quant_lat_reg <= quant_reg;
                            mode_reg      <= rec_reg ? MODE_REC : MODE_PLAY;
                            if (sub_adv)
                            begin
                                sub_reg       <= sub_reg + 1'b1;
                                sub_start_reg <= now_reg;
                                changed_reg   <= 1'b1;
                            end
                        end
                    end
                end
                S_LENDIV:
                begin
                    if (div_done)
                    begin
                        sub_len_reg <= div_quot;
                        state_reg   <= S_ROW;
                    end
                end
                S_ROW:
                begin
                    row_reg   <= row_calc[SEG_W-1:0];
                    state_reg <= S_WRITE;
                end
                S_WRITE:
                begin
                    state_reg <= changed_reg ? S_READ : S_IDLE;
                end
                S_READ:
                begin
                    state_reg <= S_OUT;
                end
                S_OUT:
                begin
                    if (out_load)
                    begin
                        changed_reg <= 1'b0;
                        state_reg   <= S_IDLE;
                    end
                end
                default:
                begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            store[mem_waddr] <= mem_wdata;
        end
        if (mem_re)
        begin
            rd_data_reg <= store[rd_addr];
        end
    end

    always_ff @(posedge clk)
    begin
        if (out_load)
        begin
            out_cv_a_reg <= rd_data_reg[CV_W-1:0];
            out_cv_b_reg <= rd_data_reg[2*CV_W-1:CV_W];
            out_gate_reg <= rd_data_reg[MEM_W-1];
            beat_out_reg <= beat_reg;
            sub_out_reg  <= sub_reg;
            mode_out_reg <= mode_reg;
        end
    end

    assign out_valid     = out_valid_reg;
    assign out_cv_a      = out_cv_a_reg;
    assign out_cv_b      = out_cv_b_reg;
    assign out_gate      = out_gate_reg;
    assign beat_index    = beat_out_reg;
    assign substep_index = sub_out_reg;
    assign run_mode      = mode_out_reg;

    a_beat_in_loop: assert property (@(posedge clk) disable iff (!rst_n)
        LEN_W'(beat_reg) < loop_len_reg)
        else $error("beat step outside loop length");

    a_sub_in_beat: assert property (@(posedge clk) disable iff (!rst_n)
        sub_reg <= SUB_LAST)
        else $error("substep past last substep");

    a_addr_in_store: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_WRITE) |-> ({1'b0, wr_addr} < (ADDR_W + 1)'(DEPTH)))
        else $error("slot address outside store");

    a_result_from_out: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid_reg) |-> $past(state_reg == S_OUT && changed_reg))
        else $error("result raised outside output state");

endmodule

// ===== verif/clock_synced_cv_recorder_top_tb.sv =====
`timescale 1ns / 1ps
// Self-checking testbench for clock_synced_cv_recorder_top: directed and random polls,
// results predicted by a local sequencer model and checked field by field.
// Depends on cvr_pkg and the recorder RTL.
module clock_synced_cv_recorder_top_tb;

    import cvr_pkg::*;

    localparam int BEATS       = TOTAL_BEATS_DEF;
    localparam int SUBSTEPS    = SUBSTEPS_DEF;
    localparam int SLOTS       = BEATS * SUBSTEPS;
    localparam int SEL_CLAMP   = 9;
    localparam int CYCLE_LIMIT = 500000;
    localparam int DRAIN_WAIT  = 40;
    localparam int LOOP_LENGTHS [10] = '{1, 2, 3, 4, 6, 8, 12, 16, 24, 32};

    typedef struct {
        logic [TS_W-1:0]   ts;
        logic              trig;
        logic              gate;
        logic [CV_W-1:0]   cva;
        logic [CV_W-1:0]   cvb;
        logic [SEL_W-1:0]  sel;
        logic [KNOB_W-1:0] knob;
        logic              rec;
        logic              quant;
    } poll_t;

    typedef struct {
        logic [CV_W-1:0]   cva;
        logic [CV_W-1:0]   cvb;
        logic              gate;
        logic [BEAT_W-1:0] beat;
        logic [SUB_W-1:0]  sub;
        run_mode_t         mode;
    } slot_t;

    logic                clk             = 1'b0;
    logic                rst_n           = 1'b0;
    logic                in_valid        = 1'b0;
    logic                in_stall;
    logic [TS_W-1:0]     time_now        = '0;
    logic                clock_trigger   = 1'b0;
    logic                gate_level      = 1'b0;
    logic [CV_W-1:0]     cv_a_sample     = '0;
    logic [CV_W-1:0]     cv_b_sample     = '0;
    logic [SEL_W-1:0]    length_select   = '0;
    logic [KNOB_W-1:0]   segment_knob    = '0;
    logic                record_switch   = 1'b0;
    logic                quantize_switch = 1'b0;
    logic                out_valid;
    logic                out_stall       = 1'b0;
    logic [CV_W-1:0]     out_cv_a;
    logic [CV_W-1:0]     out_cv_b;
    logic                out_gate;
    logic [BEAT_W-1:0]   beat_index;
    logic [SUB_W-1:0]    substep_index;
    logic [MODE_W-1:0]   run_mode;

    int send_idle_pct = 22;
    int recv_idle_pct = 63;
    int mismatches    = 0;
    int polls_sent    = 0;
    int cycles        = 0;
    logic [TS_W-1:0] poll_ts = '0;

    // sequencer state
    run_mode_t         seq_mode       = MODE_WAIT;
    logic [TS_W-1:0]   seq_edge_now   = '0;
    logic [TS_W-1:0]   seq_edge_prev  = '0;
    logic [BEAT_W-1:0] seq_beat       = '0;
    logic [SUB_W-1:0]  seq_sub        = '0;
    logic [TS_W-1:0]   seq_sub_start  = '0;
    logic [TS_W-1:0]   seq_sub_len    = '0;
    logic              seq_changed    = 1'b0;
    logic              seq_quant      = 1'b0;
    logic [LEN_W-1:0]  seq_len        = 6'd1;
    logic [BEAT_W-1:0] seq_segment    = '0;
    logic              seq_clock_seen = 1'b0;
    logic [CV_W-1:0]   cv_a_slots [SLOTS];
    logic [CV_W-1:0]   cv_b_slots [SLOTS];
    logic              gate_slots [SLOTS];
    slot_t             expected_slots [$];

    clock_synced_cv_recorder_top dut (
        .clk             (clk),
        .rst_n           (rst_n),
        .in_valid        (in_valid),
        .in_stall        (in_stall),
        .time_now        (time_now),
        .clock_trigger   (clock_trigger),
        .gate_level      (gate_level),
        .cv_a_sample     (cv_a_sample),
        .cv_b_sample     (cv_b_sample),
        .length_select   (length_select),
        .segment_knob    (segment_knob),
        .record_switch   (record_switch),
        .quantize_switch (quantize_switch),
        .out_valid       (out_valid),
        .out_stall       (out_stall),
        .out_cv_a        (out_cv_a),
        .out_cv_b        (out_cv_b),
        .out_gate        (out_gate),
        .beat_index      (beat_index),
        .substep_index   (substep_index),
        .run_mode        (run_mode)
    );

    always #10 clk = ~clk;

    always @(posedge clk)
    begin
        cycles++;
        if (cycles > CYCLE_LIMIT)
        begin
            $display("FAILURE");
            $finish;
        end
    end

    task automatic report_mismatch(input string msg);
        $display("mismatch @%0t: %s", $time, msg);
        mismatches++;
    endtask

    task automatic check_field(input string name, input int got, input int want);
        if (got != want)
            report_mismatch($sformatf("%s got %0d expected %0d", name, got, want));
    endtask

    function automatic int slot_address(input logic [SUB_W-1:0] sub);
        return (int'(seq_segment) * int'(seq_len) + int'(seq_beat)) * SUBSTEPS + int'(sub);
    endfunction

    task automatic advance_sequencer(input poll_t p);
        int          sel;
        int          nseg;
        int          addr;
        logic [TS_W-1:0] span;
        slot_t       slot;
        sel = (p.sel > SEL_CLAMP) ? SEL_CLAMP : int'(p.sel);
        if (LEN_W'(LOOP_LENGTHS[sel]) != seq_len)
        begin
            seq_len  = LEN_W'(LOOP_LENGTHS[sel]);
            seq_beat = '0;
        end
        nseg = BEATS / int'(seq_len) - 1;
        seq_segment = BEAT_W'((longint'(nseg) * longint'(p.knob) * 2 + 4095) / 8190);

        if (p.trig)
        begin
            seq_edge_prev = seq_edge_now;
            seq_edge_now  = p.ts;
            if (seq_mode == MODE_WAIT)
            begin
                if (seq_clock_seen)
                    seq_mode = MODE_PLAY;
                seq_clock_seen = 1'b1;
            end
            if (seq_mode != MODE_WAIT)
            begin
                seq_beat      = BEAT_W'((int'(seq_beat) + 1) % int'(seq_len));
                seq_sub       = '0;
                seq_sub_start = p.ts;
                span          = p.ts - seq_edge_prev;
                seq_sub_len   = span / SUBSTEPS;
                seq_changed   = 1'b1;
            end
        end
        else if (seq_mode != MODE_WAIT)
        begin
            seq_quant = p.quant;
            seq_mode  = p.rec ? MODE_REC : MODE_PLAY;
            span      = p.ts - seq_sub_start;
            if (span > seq_sub_len && int'(seq_sub) < SUBSTEPS - 1)
            begin
                seq_sub++;
                seq_sub_start = p.ts;
                seq_changed   = 1'b1;
            end
        end

        addr = slot_address(seq_sub);
        if (seq_mode == MODE_REC && seq_changed && addr < SLOTS)
        begin
            cv_a_slots[addr] = p.cva;
            cv_b_slots[addr] = p.cvb;
            gate_slots[addr] = p.gate;
        end

        if (seq_changed)
        begin
            addr = slot_address(seq_quant ? SUB_W'(0) : seq_sub);
            slot.cva  = (addr < SLOTS) ? cv_a_slots[addr] : '0;
            slot.cvb  = (addr < SLOTS) ? cv_b_slots[addr] : '0;
            slot.gate = (addr < SLOTS) ? gate_slots[addr] : 1'b0;
            slot.beat = seq_beat;
            slot.sub  = seq_sub;
            slot.mode = seq_mode;
            expected_slots.push_back(slot);
            seq_changed = 1'b0;
        end
    endtask

    // result checker and receiver stall
    always @(posedge clk)
    begin
        slot_t want;
        if (rst_n && out_valid === 1'b1 && !out_stall)
        begin
            if (expected_slots.size() == 0)
                report_mismatch("result transfer with nothing expected");
            else
            begin
                want = expected_slots.pop_front();
                check_field("out_cv_a", out_cv_a, want.cva);
                check_field("out_cv_b", out_cv_b, want.cvb);
                check_field("out_gate", out_gate, want.gate);
                check_field("beat_index", beat_index, want.beat);
                check_field("substep_index", substep_index, want.sub);
                check_field("run_mode", run_mode, want.mode);
            end
        end
        out_stall <= rst_n && ($urandom_range(99) < recv_idle_pct);
    end

    function automatic poll_t build_poll(input logic [TS_W-1:0] ts, input logic trig,
                                         input logic gate, input logic [CV_W-1:0] cva,
                                         input logic [CV_W-1:0] cvb,
                                         input logic [SEL_W-1:0] sel,
                                         input logic [KNOB_W-1:0] knob,
                                         input logic rec, input logic quant);
        poll_t p;
        p.ts = ts; p.trig = trig; p.gate = gate; p.cva = cva; p.cvb = cvb;
        p.sel = sel; p.knob = knob; p.rec = rec; p.quant = quant;
        return p;
    endfunction

    task automatic send_poll(input poll_t p);
        while ($urandom_range(99) < send_idle_pct)
        begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid        <= 1'b1;
        time_now        <= p.ts;
        clock_trigger   <= p.trig;
        gate_level      <= p.gate;
        cv_a_sample     <= p.cva;
        cv_b_sample     <= p.cvb;
        length_select   <= p.sel;
        segment_knob    <= p.knob;
        record_switch   <= p.rec;
        quantize_switch <= p.quant;
        @(posedge clk);
        while (in_stall !== 1'b0)
            @(posedge clk);
        advance_sequencer(p);
        polls_sent++;
    endtask

    function automatic poll_t random_poll(input logic [TS_W-1:0] ts, input logic trig,
                                          input logic [SEL_W-1:0] sel,
                                          input logic [KNOB_W-1:0] knob,
                                          input logic rec, input logic quant);
        return build_poll(ts, trig, 1'($urandom), CV_W'($urandom), CV_W'($urandom),
                          sel, knob, rec, quant);
    endfunction

    task automatic test_wait_for_clock;
        send_poll(build_poll(32'd5, 1'b0, 1'b1, 12'hFFF, 12'hFFF, 4'd15, 12'hFFF, 1'b1, 1'b1));
        send_poll(build_poll(32'd0, 1'b1, 1'b0, 12'h000, 12'h000, 4'd0, 12'h000, 1'b0, 1'b0));
        send_poll(build_poll(32'd40, 1'b0, 1'b1, 12'h123, 12'h456, 4'd0, 12'hFFF, 1'b1, 1'b0));
        send_poll(build_poll(32'd70, 1'b0, 1'b0, 12'h789, 12'hABC, 4'd0, 12'hFFF, 1'b0, 1'b1));
        send_poll(build_poll(32'd100, 1'b1, 1'b1, 12'hFFF, 12'h000, 4'd0, 12'hFFF, 1'b1, 1'b0));
    endtask

    task automatic test_substep_recording;
        send_poll(build_poll(32'd110, 1'b0, 1'b1, 12'hFFF, 12'h000, 4'd0, 12'hFFF, 1'b1, 1'b0));
        send_poll(build_poll(32'd126, 1'b0, 1'b1, 12'h000, 12'hFFF, 4'd0, 12'hFFF, 1'b1, 1'b0));
        send_poll(build_poll(32'd152, 1'b0, 1'b0, 12'h800, 12'h7FF, 4'd0, 12'hFFF, 1'b1, 1'b0));
        send_poll(build_poll(32'd178, 1'b0, 1'b1, 12'hFFF, 12'hFFF, 4'd0, 12'hFFF, 1'b1, 1'b0));
        send_poll(build_poll(32'd300, 1'b0, 1'b0, 12'h555, 12'hAAA, 4'd0, 12'hFFF, 1'b1, 1'b0));
        send_poll(build_poll(32'd300, 1'b1, 1'b1, 12'hAAA, 12'h555, 4'd0, 12'hFFF, 1'b1, 1'b0));
        // repeated edge time gives a zero substep length
        send_poll(build_poll(32'd300, 1'b1, 1'b0, 12'h001, 12'hFFE, 4'd0, 12'hFFF, 1'b1, 1'b0));
        send_poll(build_poll(32'd301, 1'b0, 1'b1, 12'h3C3, 12'hC3C, 4'd0, 12'hFFF, 1'b1, 1'b0));
        send_poll(build_poll(32'd302, 1'b0, 1'b0, 12'h0F0, 12'hF0F, 4'd0, 12'hFFF, 1'b0, 1'b1));
        send_poll(build_poll(32'd303, 1'b0, 1'b1, 12'h111, 12'h222, 4'd0, 12'hFFF, 1'b0, 1'b0));
    endtask

    task automatic test_length_and_segment;
        send_poll(build_poll(32'd310, 1'b0, 1'b1, 12'h321, 12'h654, 4'd3, 12'hFFF, 1'b0, 1'b0));
        send_poll(build_poll(32'd400, 1'b1, 1'b0, 12'h987, 12'hCBA, 4'd3, 12'h800, 1'b0, 1'b0));
        send_poll(build_poll(32'd500, 1'b1, 1'b1, 12'hFED, 12'h012, 4'd12, 12'hFFF, 1'b1, 1'b1));
        send_poll(build_poll(32'd530, 1'b0, 1'b1, 12'h246, 12'h8AC, 4'd12, 12'hFFF, 1'b1, 1'b1));
        send_poll(build_poll(32'd600, 1'b1, 1'b0, 12'h135, 12'h79B, 4'd9, 12'h000, 1'b0, 1'b0));
        send_poll(build_poll(32'd700, 1'b1, 1'b1, 12'hDEF, 12'hFED, 4'd7, 12'h001, 1'b1, 1'b0));
        send_poll(build_poll(32'd760, 1'b0, 1'b0, 12'h444, 12'hBBB, 4'd7, 12'h001, 1'b0, 1'b0));
        poll_ts = 32'd800;
    endtask

    // a run of beats, polls in between, occasional length, knob, record and quantize changes
    task automatic send_clocked_run;
        int              beats;
        int              period;
        int              polls;
        int              pick;
        logic [SEL_W-1:0]  sel;
        logic [KNOB_W-1:0] knob;
        logic            rec;
        logic            quant;
        pick   = $urandom_range(99);
        period = (pick < 5) ? 0 : (pick < 85) ? $urandom_range(8, 400)
                                              : $urandom_range(401, 1 << 24);
        beats  = $urandom_range(2, 10);
        sel    = SEL_W'($urandom_range(15));
        knob   = KNOB_W'($urandom);
        rec    = 1'($urandom);
        quant  = 1'($urandom);
        if ($urandom_range(19) == 0)
            poll_ts = 32'hFFFF_FFFF - $urandom_range(2000);
        for (int b = 0; b < beats; b++)
        begin
            if ($urandom_range(9) == 0)
                sel = SEL_W'($urandom_range(15));
            if ($urandom_range(4) == 0)
                knob = KNOB_W'($urandom);
            if ($urandom_range(4) == 0)
                rec = ~rec;
            if ($urandom_range(4) == 0)
                quant = ~quant;
            send_poll(random_poll(poll_ts, 1'b1, sel, knob, 1'($urandom), 1'($urandom)));
            polls = $urandom_range(0, 6);
            for (int k = 0; k < polls; k++)
            begin
                poll_ts += $urandom_range(0, period / 3 + 1);
                send_poll(random_poll(poll_ts, 1'b0, sel, knob, rec, quant));
            end
            poll_ts += $urandom_range(0, period / 3 + 1);
        end
    endtask

    task automatic test_random_traffic(input int send_pct, input int recv_pct, input int count);
        int target;
        send_idle_pct = send_pct;
        recv_idle_pct = recv_pct;
        target = polls_sent + count;
        while (polls_sent < target)
        begin
            if ($urandom_range(99) < 12)
                send_poll(random_poll(TS_W'($urandom), 1'($urandom), SEL_W'($urandom),
                                      KNOB_W'($urandom), 1'($urandom), 1'($urandom)));
            else
                send_clocked_run();
        end
    endtask

    initial
    begin
        for (int i = 0; i < SLOTS; i++)
        begin
            cv_a_slots[i] = '0;
            cv_b_slots[i] = '0;
            gate_slots[i] = 1'b0;
        end
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_wait_for_clock();
        test_substep_recording();
        test_length_and_segment();
        test_random_traffic(22, 63, 420);
        test_random_traffic(63, 22, 420);
        test_random_traffic(0, 0, 410);

        in_valid <= 1'b0;
        while (expected_slots.size() != 0)
            @(posedge clk);
        repeat (DRAIN_WAIT) @(posedge clk);

        if (mismatches == 0)
            $display("SUCCESS");
        else
            $display("FAILURE");
        $finish;
    end

endmodule
